// ===== rtl/reh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reh_pkg
// Shared types and constants for the radial energy histogram unit.
// ----------------------------------------------------------------------------

package reh_pkg;

    // field widths
    localparam int POS_W      = 16;
    localparam int ABS_W      = 16;
    localparam int OP_W       = 17;
    localparam int SQ_W       = 34;
    localparam int DIST_W     = 17;
    localparam int EN_W       = 16;
    localparam int BIN_HIT_W  = 7;
    localparam int READ_BIN_W = 7;
    localparam int CONTENT_W  = 32;
    localparam int SUM_W      = 48;
    localparam int WIDTH_W    = 16;
    localparam int REM_W      = 20;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // sequencer step limits
    localparam logic [CNT_W-1:0] MUL_LAST  = 5'd4;
    localparam logic [CNT_W-1:0] ITER_LAST = 5'd16;

    // item function codes
    localparam logic FUNC_HIT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // register reset values
    localparam logic signed [POS_W-1:0] VERTEX_X_RST       = 16'sd600;
    localparam logic signed [POS_W-1:0] VERTEX_Y_RST       = 16'sd600;
    localparam logic signed [POS_W-1:0] VERTEX_Z_RST       = 16'sd0;
    localparam logic [DIST_W-1:0]       NEAR_THRESHOLD_RST = 17'd1600;
    localparam logic [WIDTH_W-1:0]      BIN_WIDTH_RST      = 16'd457;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_X       = 3'd0,
        CFG_VERTEX_Y       = 3'd1,
        CFG_VERTEX_Z       = 3'd2,
        CFG_NEAR_THRESHOLD = 3'd3,
        CFG_BIN_WIDTH      = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_DIV,
        ST_RD,
        ST_UPD
    } state_t;

endpackage

// ===== rtl/radial_energy_histogram_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_energy_histogram_unit
// Radial distance of detector hits to a vertex, binned energy histogram,
// highest-energy tracking and near/far energy sums.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | words
//  ---------+---------------------+----------------------------------------------
//  in       | in_valid / in_stall | func, hit_x, hit_y, hit_z, energy, read_bin
//  out      | out_valid/out_stall | distance, bin_hit, highest_energy,
//           |                     | highest_distance, near_sum, far_sum,
//           |                     | bin_content
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  a hit word runs through 5 steps on one shared 17x17 multiplier (three
//  squares and the squared threshold), 17 square-root iterations, 17 divide
//  iterations, a bin memory read and a write-back
//  a read word runs through accept, bin memory read and result
//  one word is worked at a time; the next is taken once the previous result
//  sits in the output register, even while out_stall holds it there
//  reset clears the bins through per-entry valid bits at once, no clearing pass
//  cfg_ready is always high

module radial_energy_histogram_unit #(
    parameter int NUM_BINS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  func,
    input  logic signed [reh_pkg::POS_W-1:0]      hit_x,
    input  logic signed [reh_pkg::POS_W-1:0]      hit_y,
    input  logic signed [reh_pkg::POS_W-1:0]      hit_z,
    input  logic [reh_pkg::EN_W-1:0]              energy,
    input  logic [reh_pkg::READ_BIN_W-1:0]        read_bin,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [reh_pkg::DIST_W-1:0]            distance,
    output logic [reh_pkg::BIN_HIT_W-1:0]         bin_hit,
    output logic [reh_pkg::EN_W-1:0]              highest_energy,
    output logic [reh_pkg::DIST_W-1:0]            highest_distance,
    output logic [reh_pkg::SUM_W-1:0]             near_sum,
    output logic [reh_pkg::SUM_W-1:0]             far_sum,
    output logic [reh_pkg::CONTENT_W-1:0]         bin_content,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [reh_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [reh_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int BIN_IW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [reh_pkg::DIST_W-1:0] NB17 = 17'(NUM_BINS);

    // configuration registers
    logic signed [reh_pkg::POS_W-1:0]   vertex_x_reg;
    logic signed [reh_pkg::POS_W-1:0]   vertex_y_reg;
    logic signed [reh_pkg::POS_W-1:0]   vertex_z_reg;
    logic [reh_pkg::DIST_W-1:0]         near_threshold_reg;
    logic [reh_pkg::WIDTH_W-1:0]        bin_width_reg;

    // sequencer
    reh_pkg::state_t                    state_reg;
    reh_pkg::state_t                    state_next;
    logic [reh_pkg::CNT_W-1:0]          cnt_reg;
    logic                               rd_en;
    logic                               upd_go;
    logic                               slot_free;

    // item registers
    logic                               func_reg;
    logic [reh_pkg::EN_W-1:0]           energy_reg;
    logic [reh_pkg::ABS_W-1:0]          abs_reg [3];
    logic [reh_pkg::DIST_W-1:0]         target_reg;

    // squares
    logic [reh_pkg::OP_W-1:0]           mul_op;
    logic [reh_pkg::SQ_W-1:0]           mul_p;
    logic [reh_pkg::SQ_W-1:0]           prod_reg;
    logic [reh_pkg::SQ_W-1:0]           d2_reg;
    logic                               near_reg;

    // square root
    logic [reh_pkg::SQ_W-1:0]           sq_rad_reg;
    logic [reh_pkg::REM_W-1:0]          sq_rem_reg;
    logic [reh_pkg::DIST_W-1:0]         root_reg;
    logic [reh_pkg::REM_W-1:0]          rem_sh;
    logic [reh_pkg::REM_W-1:0]          trial;
    logic                               sq_ge;
    logic [reh_pkg::REM_W-1:0]          rem_new;
    logic [reh_pkg::DIST_W-1:0]         root_new;
    logic [reh_pkg::DIST_W-1:0]         dist_reg;

    // divide by bin width
    logic [reh_pkg::DIST_W-1:0]         div_q_reg;
    logic [reh_pkg::DIST_W-1:0]         div_rem_reg;
    logic [reh_pkg::WIDTH_W-1:0]        w_eff;
    logic [reh_pkg::DIST_W-1:0]         drem_sh;
    logic                               div_ge;
    logic [reh_pkg::DIST_W-1:0]         drem_new;
    logic [reh_pkg::DIST_W-1:0]         dq_new;

    // bin memory
    logic [reh_pkg::CONTENT_W-1:0]      bin_mem [NUM_BINS];
    logic [NUM_BINS-1:0]                bin_valid_reg;
    logic [reh_pkg::CONTENT_W-1:0]      rdata_reg;
    logic                               ent_valid_reg;
    logic [BIN_IW-1:0]                  addr;
    logic                               wr_en;

    // accumulators
    logic [reh_pkg::CONTENT_W-1:0]      overflow_reg;
    logic [reh_pkg::EN_W-1:0]           best_energy_reg;
    logic [reh_pkg::DIST_W-1:0]         best_distance_reg;
    logic [reh_pkg::SUM_W-1:0]          near_total_reg;
    logic [reh_pkg::SUM_W-1:0]          far_total_reg;

    // update datapath
    logic                               in_range;
    logic                               is_ovf;
    logic                               hit_go;
    logic [reh_pkg::CONTENT_W-1:0]      entry;
    logic [reh_pkg::CONTENT_W-1:0]      base;
    logic [reh_pkg::CONTENT_W:0]        sum33;
    logic [reh_pkg::CONTENT_W-1:0]      new_content;
    logic                               best_take;
    logic [reh_pkg::SUM_W:0]            near49;
    logic [reh_pkg::SUM_W:0]            far49;
    logic [reh_pkg::SUM_W-1:0]          near_sat;
    logic [reh_pkg::SUM_W-1:0]          far_sat;

    // output register
    logic                               out_valid_reg;
    logic [reh_pkg::DIST_W-1:0]         distance_reg;
    logic [reh_pkg::BIN_HIT_W-1:0]      bin_hit_reg;
    logic [reh_pkg::EN_W-1:0]           highest_energy_reg;
    logic [reh_pkg::DIST_W-1:0]         highest_distance_reg;
    logic [reh_pkg::SUM_W-1:0]          near_sum_reg;
    logic [reh_pkg::SUM_W-1:0]          far_sum_reg;
    logic [reh_pkg::CONTENT_W-1:0]      bin_content_reg;

    // differences to the vertex and their negations
    logic signed [reh_pkg::OP_W-1:0]    dx;
    logic signed [reh_pkg::OP_W-1:0]    dy;
    logic signed [reh_pkg::OP_W-1:0]    dz;
    logic [reh_pkg::OP_W-1:0]           ndx;
    logic [reh_pkg::OP_W-1:0]           ndy;
    logic [reh_pkg::OP_W-1:0]           ndz;

    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_x_reg       <= reh_pkg::VERTEX_X_RST;
            vertex_y_reg       <= reh_pkg::VERTEX_Y_RST;
            vertex_z_reg       <= reh_pkg::VERTEX_Z_RST;
            near_threshold_reg <= reh_pkg::NEAR_THRESHOLD_RST;
            bin_width_reg      <= reh_pkg::BIN_WIDTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                reh_pkg::CFG_VERTEX_X:       vertex_x_reg <= cfg_data[reh_pkg::POS_W-1:0];
                reh_pkg::CFG_VERTEX_Y:       vertex_y_reg <= cfg_data[reh_pkg::POS_W-1:0];
                reh_pkg::CFG_VERTEX_Z:       vertex_z_reg <= cfg_data[reh_pkg::POS_W-1:0];
                reh_pkg::CFG_NEAR_THRESHOLD: near_threshold_reg <= cfg_data;
                reh_pkg::CFG_BIN_WIDTH:      bin_width_reg <= cfg_data[reh_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            reh_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (func == reh_pkg::FUNC_READ) ? reh_pkg::ST_RD
                                                              : reh_pkg::ST_MUL;
                end
            end
            reh_pkg::ST_MUL:
            begin
                if (cnt_reg == reh_pkg::MUL_LAST)
                begin
                    state_next = reh_pkg::ST_SQRT;
                end
            end
            reh_pkg::ST_SQRT:
            begin
                if (cnt_reg == reh_pkg::ITER_LAST)
                begin
                    state_next = reh_pkg::ST_DIV;
                end
            end
            reh_pkg::ST_DIV:
            begin
                if (cnt_reg == reh_pkg::ITER_LAST)
                begin
                    state_next = reh_pkg::ST_RD;
                end
            end
            reh_pkg::ST_RD:
            begin
                state_next = reh_pkg::ST_UPD;
            end
            reh_pkg::ST_UPD:
            begin
                if (slot_free)
                begin
                    state_next = reh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = reh_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        rd_en    = 1'b0;
        upd_go   = 1'b0;
        case (state_reg)
            reh_pkg::ST_IDLE: in_stall = 1'b0;
            reh_pkg::ST_RD:   rd_en = 1'b1;
            reh_pkg::ST_UPD:  upd_go = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= reh_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == reh_pkg::ST_MUL || state_reg == reh_pkg::ST_SQRT ||
                 state_reg == reh_pkg::ST_DIV) && state_next == state_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // arithmetic steps
    // ------------------------------------------------------------------
    assign dx  = {hit_x[reh_pkg::POS_W-1], hit_x} - {vertex_x_reg[reh_pkg::POS_W-1], vertex_x_reg};
    assign dy  = {hit_y[reh_pkg::POS_W-1], hit_y} - {vertex_y_reg[reh_pkg::POS_W-1], vertex_y_reg};
    assign dz  = {hit_z[reh_pkg::POS_W-1], hit_z} - {vertex_z_reg[reh_pkg::POS_W-1], vertex_z_reg};
    assign ndx = -dx;
    assign ndy = -dy;
    assign ndz = -dz;

    // three squares, then the squared threshold, on one multiplier
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    mul_op = {1'b0, abs_reg[0]};
            2'd1:    mul_op = {1'b0, abs_reg[1]};
            2'd2:    mul_op = {1'b0, abs_reg[2]};
            default: mul_op = near_threshold_reg;
        endcase
    end

    assign mul_p = mul_op * mul_op;

    // restoring square root, one result bit per cycle
    assign rem_sh   = {sq_rem_reg[reh_pkg::REM_W-3:0], sq_rad_reg[reh_pkg::SQ_W-1 -: 2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign sq_ge    = rem_sh >= trial;
    assign rem_new  = sq_ge ? (rem_sh - trial) : rem_sh;
    assign root_new = {root_reg[reh_pkg::DIST_W-2:0], sq_ge};

    // restoring divide by the bin width, zero width acts as one
    assign w_eff    = (bin_width_reg == '0) ? 16'd1 : bin_width_reg;
    assign drem_sh  = {div_rem_reg[reh_pkg::DIST_W-2:0], div_q_reg[reh_pkg::DIST_W-1]};
    assign div_ge   = drem_sh >= {1'b0, w_eff};
    assign drem_new = div_ge ? (drem_sh - {1'b0, w_eff}) : drem_sh;
    assign dq_new   = {div_q_reg[reh_pkg::DIST_W-2:0], div_ge};

    always_ff @(posedge clk)
    begin
        case (state_reg)
            reh_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_reg   <= func;
                    energy_reg <= energy;
                    abs_reg[0] <= dx[reh_pkg::OP_W-1] ? ndx[reh_pkg::ABS_W-1:0]
                                                      : dx[reh_pkg::ABS_W-1:0];
                    abs_reg[1] <= dy[reh_pkg::OP_W-1] ? ndy[reh_pkg::ABS_W-1:0]
                                                      : dy[reh_pkg::ABS_W-1:0];
                    abs_reg[2] <= dz[reh_pkg::OP_W-1] ? ndz[reh_pkg::ABS_W-1:0]
                                                      : dz[reh_pkg::ABS_W-1:0];
                    d2_reg     <= '0;
                    target_reg <= {10'd0, read_bin};
                end
            end
            reh_pkg::ST_MUL:
            begin
                if (cnt_reg != reh_pkg::MUL_LAST)
                begin
                    prod_reg <= mul_p;
                end
                // the product registered in the previous step joins the sum
                if (cnt_reg != '0 && cnt_reg != reh_pkg::MUL_LAST)
                begin
                    d2_reg <= d2_reg + prod_reg;
                end
                if (cnt_reg == reh_pkg::MUL_LAST)
                begin
                    near_reg   <= d2_reg <= prod_reg;
                    sq_rad_reg <= d2_reg;
                    sq_rem_reg <= '0;
                    root_reg   <= '0;
                end
            end
            reh_pkg::ST_SQRT:
            begin
                sq_rad_reg <= {sq_rad_reg[reh_pkg::SQ_W-3:0], 2'b00};
                sq_rem_reg <= rem_new;
                root_reg   <= root_new;
                if (cnt_reg == reh_pkg::ITER_LAST)
                begin
                    dist_reg    <= root_new;
                    div_q_reg   <= root_new;
                    div_rem_reg <= '0;
                end
            end
            reh_pkg::ST_DIV:
            begin
                div_q_reg   <= dq_new;
                div_rem_reg <= drem_new;
                if (cnt_reg == reh_pkg::ITER_LAST)
                begin
                    target_reg <= dq_new;
                end
            end
            reh_pkg::ST_RD:
            begin
                ent_valid_reg <= bin_valid_reg[addr];
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // bin memory, read in ST_RD and written back in ST_UPD of the same
    // word, so a read never overlaps a pending write
    // ------------------------------------------------------------------
    assign in_range = target_reg < NB17;
    assign is_ovf   = target_reg == NB17;
    assign addr     = target_reg[BIN_IW-1:0];

    always_ff @(posedge clk)
    begin
        if (rd_en && in_range)
        begin
            rdata_reg <= bin_mem[addr];
        end
        if (wr_en)
        begin
            bin_mem[addr] <= new_content;
        end
    end

    // ------------------------------------------------------------------
    // update
    // ------------------------------------------------------------------
    assign hit_go = upd_go && (func_reg == reh_pkg::FUNC_HIT);
    assign wr_en  = hit_go && in_range;

    // never written entries read as zero
    assign entry = ent_valid_reg ? rdata_reg : '0;

    always_comb
    begin
        if (in_range)
        begin
            base = entry;
        end
        else if (is_ovf || func_reg == reh_pkg::FUNC_HIT)
        begin
            base = overflow_reg;
        end
        else
        begin
            base = '0;
        end
    end

    assign sum33       = {1'b0, base} + {17'd0, energy_reg};
    assign new_content = sum33[reh_pkg::CONTENT_W] ? '1 : sum33[reh_pkg::CONTENT_W-1:0];
    assign best_take   = energy_reg > best_energy_reg;
    assign near49      = {1'b0, near_total_reg} + {33'd0, energy_reg};
    assign far49       = {1'b0, far_total_reg} + {33'd0, energy_reg};
    assign near_sat    = near49[reh_pkg::SUM_W] ? '1 : near49[reh_pkg::SUM_W-1:0];
    assign far_sat     = far49[reh_pkg::SUM_W] ? '1 : far49[reh_pkg::SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg     <= '0;
            overflow_reg      <= '0;
            best_energy_reg   <= '0;
            best_distance_reg <= '0;
            near_total_reg    <= '0;
            far_total_reg     <= '0;
        end
        else if (hit_go)
        begin
            if (in_range)
            begin
                bin_valid_reg[addr] <= 1'b1;
            end
            else
            begin
                overflow_reg <= new_content;
            end
            if (best_take)
            begin
                best_energy_reg   <= energy_reg;
                best_distance_reg <= dist_reg;
            end
            if (near_reg)
            begin
                near_total_reg <= near_sat;
            end
            else
            begin
                far_total_reg <= far_sat;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (upd_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_go)
        begin
            if (func_reg == reh_pkg::FUNC_HIT)
            begin
                distance_reg         <= dist_reg;
                bin_hit_reg          <= in_range ? target_reg[reh_pkg::BIN_HIT_W-1:0]
                                                 : NB17[reh_pkg::BIN_HIT_W-1:0];
                highest_energy_reg   <= best_take ? energy_reg : best_energy_reg;
                highest_distance_reg <= best_take ? dist_reg : best_distance_reg;
                near_sum_reg         <= near_reg ? near_sat : near_total_reg;
                far_sum_reg          <= near_reg ? far_total_reg : far_sat;
                bin_content_reg      <= new_content;
            end
            else
            begin
                distance_reg         <= '0;
                bin_hit_reg          <= '0;
                highest_energy_reg   <= best_energy_reg;
                highest_distance_reg <= best_distance_reg;
                near_sum_reg         <= near_total_reg;
                far_sum_reg          <= far_total_reg;
                bin_content_reg      <= base;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign distance         = distance_reg;
    assign bin_hit          = bin_hit_reg;
    assign highest_energy   = highest_energy_reg;
    assign highest_distance = highest_distance_reg;
    assign near_sum         = near_sum_reg;
    assign far_sum          = far_sum_reg;
    assign bin_content      = bin_content_reg;

endmodule

// ===== rtl/reh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reh_checker
// Port-level checks for the radial energy histogram unit, bound to the top.
// ----------------------------------------------------------------------------

module reh_checker #(
    parameter int NUM_BINS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  func,
    input  logic signed [reh_pkg::POS_W-1:0]      hit_x,
    input  logic signed [reh_pkg::POS_W-1:0]      hit_y,
    input  logic signed [reh_pkg::POS_W-1:0]      hit_z,
    input  logic [reh_pkg::EN_W-1:0]              energy,
    input  logic [reh_pkg::READ_BIN_W-1:0]        read_bin,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic [reh_pkg::DIST_W-1:0]            distance,
    input  logic [reh_pkg::BIN_HIT_W-1:0]         bin_hit,
    input  logic [reh_pkg::EN_W-1:0]              highest_energy,
    input  logic [reh_pkg::DIST_W-1:0]            highest_distance,
    input  logic [reh_pkg::SUM_W-1:0]             near_sum,
    input  logic [reh_pkg::SUM_W-1:0]             far_sum,
    input  logic [reh_pkg::CONTENT_W-1:0]         bin_content,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [reh_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [reh_pkg::CFG_DATA_W-1:0]        cfg_data
);

    // one word in flight: an accepted word blocks the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while a word is in flight");

    // a new result only comes out of a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a word in work");

    // held result word does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bin_content)
            && $stable(near_sum) && $stable(far_sum) && $stable(distance))
        else $error("stalled result word changed");

    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {25'd0, bin_hit} <= NUM_BINS)
        else $error("bin_hit beyond overflow index");

    // no best hit yet means no best distance either
    a_best_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && highest_energy == '0 |-> highest_distance == '0)
        else $error("highest_distance set without a best hit");

endmodule

bind radial_energy_histogram_unit reh_checker #(.NUM_BINS(NUM_BINS)) u_reh_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for radial_energy_histogram_unit: a short table of
// directed hits and bin reads, then several register settings with random
// hits, mostly around the vertex, and bin reads; each result is checked
// against the table or a local predictor of the bins, peak tracking and near/far sums.
// ----------------------------------------------------------------------------

module tb;

    import reh_pkg::*;

    localparam int BINS          = 64;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 104;
    localparam int SETTLE_CYCLES = 60;
    localparam int QUIET_LIMIT   = 3000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam longint unsigned COUNT_MAX = 64'hFFFF_FFFF;
    localparam longint unsigned SUM_MAX   = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [DIST_W-1:0]    distance;
        logic [BIN_HIT_W-1:0] bin_hit;
        logic [EN_W-1:0]      highest_energy;
        logic [DIST_W-1:0]    highest_distance;
        logic [SUM_W-1:0]     near_sum;
        logic [SUM_W-1:0]     far_sum;
        logic [CONTENT_W-1:0] bin_content;
    } hist_result_t;

    typedef struct {
        logic         f;
        int           x;
        int           y;
        int           z;
        int           e;
        int           rb;
        bit           typed;
        hist_result_t want;
    } probe_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic                         func;
    logic signed [POS_W-1:0]      hit_x;
    logic signed [POS_W-1:0]      hit_y;
    logic signed [POS_W-1:0]      hit_z;
    logic [EN_W-1:0]              energy;
    logic [READ_BIN_W-1:0]        read_bin;
    logic                         out_valid;
    logic                         out_stall;
    logic [DIST_W-1:0]            distance;
    logic [BIN_HIT_W-1:0]         bin_hit;
    logic [EN_W-1:0]              highest_energy;
    logic [DIST_W-1:0]            highest_distance;
    logic [SUM_W-1:0]             near_sum;
    logic [SUM_W-1:0]             far_sum;
    logic [CONTENT_W-1:0]         bin_content;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;

    // predictor state
    logic [CONTENT_W-1:0] hist_bins [BINS];
    logic [CONTENT_W-1:0] ovf_total;
    logic [EN_W-1:0]      peak_energy;
    logic [DIST_W-1:0]    peak_dist;
    logic [SUM_W-1:0]     sum_near;
    logic [SUM_W-1:0]     sum_far;
    longint               org_x;
    longint               org_y;
    longint               org_z;
    logic [DIST_W-1:0]    near_lim;
    logic [WIDTH_W-1:0]   bin_span;

    hist_result_t pending_results [$];
    int           fail_count = 0;

    radial_energy_histogram_unit #(
        .NUM_BINS (BINS)
    ) dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned pause_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        longint unsigned rest;
        root  = 0;
        rest  = v;
        probe = 64'd1 << 62;
        while (probe > rest)
            probe >>= 2;
        while (probe != 0)
        begin
            if (rest >= root + probe)
            begin
                rest -= root + probe;
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned clip_add(input longint unsigned a,
                                                 input longint unsigned b,
                                                 input longint unsigned top);
        return (a + b > top) ? top : a + b;
    endfunction

    function automatic void reset_model();
        foreach (hist_bins[i])
            hist_bins[i] = '0;
        ovf_total   = '0;
        peak_energy = '0;
        peak_dist   = '0;
        sum_near    = '0;
        sum_far     = '0;
        org_x       = longint'(VERTEX_X_RST);
        org_y       = longint'(VERTEX_Y_RST);
        org_z       = longint'(VERTEX_Z_RST);
        near_lim    = NEAR_THRESHOLD_RST;
        bin_span    = BIN_WIDTH_RST;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_VERTEX_X:       org_x = longint'($signed(data[POS_W-1:0]));
            CFG_VERTEX_Y:       org_y = longint'($signed(data[POS_W-1:0]));
            CFG_VERTEX_Z:       org_z = longint'($signed(data[POS_W-1:0]));
            CFG_NEAR_THRESHOLD: near_lim = data[DIST_W-1:0];
            CFG_BIN_WIDTH:      bin_span = data[WIDTH_W-1:0];
            default:            ;
        endcase
    endfunction

    // updates the histogram state for one word and returns the result it gives
    function automatic hist_result_t histogram_predict(input logic f,
                                                       input logic signed [POS_W-1:0] x,
                                                       input logic signed [POS_W-1:0] y,
                                                       input logic signed [POS_W-1:0] z,
                                                       input logic [EN_W-1:0] e,
                                                       input logic [READ_BIN_W-1:0] rb);
        hist_result_t    r;
        longint          dx;
        longint          dy;
        longint          dz;
        longint          d2;
        longint unsigned root;
        longint unsigned span;
        longint unsigned slot;
        r.distance    = '0;
        r.bin_hit     = '0;
        r.bin_content = '0;
        if (f == FUNC_HIT)
        begin
            dx   = longint'(x) - org_x;
            dy   = longint'(y) - org_y;
            dz   = longint'(z) - org_z;
            d2   = dx * dx + dy * dy + dz * dz;
            root = floor_root(d2);
            span = (bin_span == 0) ? 1 : longint'(bin_span);
            slot = root / span;
            r.distance = root[DIST_W-1:0];
            if (slot < BINS)
            begin
                hist_bins[slot] = clip_add(hist_bins[slot], e, COUNT_MAX);
                r.bin_content   = hist_bins[slot];
                r.bin_hit       = slot[BIN_HIT_W-1:0];
            end
            else
            begin
                ovf_total     = clip_add(ovf_total, e, COUNT_MAX);
                r.bin_content = ovf_total;
                r.bin_hit     = BIN_HIT_W'(BINS);
            end
            if (e > peak_energy)
            begin
                peak_energy = e;
                peak_dist   = root[DIST_W-1:0];
            end
            if (d2 <= longint'(near_lim) * longint'(near_lim))
                sum_near = clip_add(sum_near, e, SUM_MAX);
            else
                sum_far = clip_add(sum_far, e, SUM_MAX);
        end
        else
        begin
            if (rb < BINS)
                r.bin_content = hist_bins[rb];
            else if (rb == BINS)
                r.bin_content = ovf_total;
        end
        r.highest_energy   = peak_energy;
        r.highest_distance = peak_dist;
        r.near_sum         = sum_near;
        r.far_sum          = sum_far;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic signed [POS_W-1:0] around(input longint center,
                                                       input longint spread);
        longint c;
        c = center + longint'($urandom_range(0, 32'(2 * spread))) - spread;
        if (c > 32767)
            c = 32767;
        else if (c < -32768)
            c = -32768;
        return c[POS_W-1:0];
    endfunction

    function automatic logic [EN_W-1:0] pick_energy();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return peak_energy;
        if (roll < 30)
            return '1;
        if (roll < 50)
            return EN_W'($urandom_range(1, 255));
        return EN_W'($urandom);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        apply_reg(idx, data);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] vx,
                                input logic [CFG_DATA_W-1:0] vy,
                                input logic [CFG_DATA_W-1:0] vz,
                                input logic [CFG_DATA_W-1:0] thr,
                                input logic [CFG_DATA_W-1:0] bw,
                                input bit poke_spare);
        write_reg(CFG_VERTEX_X, vx);
        // unmapped index must leave every register alone
        if (poke_spare)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      CFG_DATA_W'($urandom));
        write_reg(CFG_VERTEX_Y, vy);
        write_reg(CFG_VERTEX_Z, vz);
        write_reg(CFG_NEAR_THRESHOLD, thr);
        write_reg(CFG_BIN_WIDTH, bw);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // valid stays high after the word is taken only when the next word follows at once
    task automatic send_word(input logic f,
                             input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y,
                             input logic signed [POS_W-1:0] z,
                             input logic [EN_W-1:0] e,
                             input logic [READ_BIN_W-1:0] rb,
                             input int unsigned gap,
                             output hist_result_t predicted);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        func     <= f;
        hit_x    <= x;
        hit_y    <= y;
        hit_z    <= z;
        energy   <= e;
        read_bin <= rb;
        do @(posedge clk); while (in_stall !== 1'b0);
        predicted = histogram_predict(f, x, y, z, e, rb);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : result_monitor
        hist_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with no word pending");
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("distance", want.distance, distance);
                    compare_field("bin_hit", want.bin_hit, bin_hit);
                    compare_field("highest_energy", want.highest_energy, highest_energy);
                    compare_field("highest_distance", want.highest_distance,
                                  highest_distance);
                    compare_field("near_sum", want.near_sum, near_sum);
                    compare_field("far_sum", want.far_sum, far_sum);
                    compare_field("bin_content", want.bin_content, bin_content);
                end
            end
        end
    end

    initial
    begin : sink_pacing
        int unsigned busy_n;
        int unsigned free_n;
        out_stall = 1'b0;
        forever
        begin
            busy_n = pause_len();
            free_n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(1, 6);
            repeat (busy_n)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            repeat (free_n)
            begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        probe_row_t              dir_rows [20];
        hist_result_t            predicted;
        logic                    f;
        logic signed [POS_W-1:0] hx;
        logic signed [POS_W-1:0] hy;
        logic signed [POS_W-1:0] hz;
        logic [EN_W-1:0]         en;
        logic [READ_BIN_W-1:0]   rb;
        logic [CFG_DATA_W-1:0]   vx;
        logic [CFG_DATA_W-1:0]   vy;
        logic [CFG_DATA_W-1:0]   vz;
        logic [CFG_DATA_W-1:0]   thr;
        logic [CFG_DATA_W-1:0]   bw;
        longint                  spread;
        int unsigned             roll;
        bit                      steady;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = FUNC_HIT;
        hit_x     = '0;
        hit_y     = '0;
        hit_z     = '0;
        energy    = '0;
        read_bin  = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_VERTEX_X;
        cfg_data  = '0;
        reset_model();

        dir_rows = '{
            // reads of an empty histogram, up to and beyond the overflow slot
            '{FUNC_READ, 11, -7, 3, 9, 0, 1'b1, '{0, 0, 0, 0, 0, 0, 0}},
            '{FUNC_READ, 0, 0, 0, 0, 64, 1'b1, '{0, 0, 0, 0, 0, 0, 0}},
            '{FUNC_READ, -1, -1, -1, 65535, 127, 1'b1, '{0, 0, 0, 0, 0, 0, 0}},
            // hit right on the vertex
            '{FUNC_HIT, 600, 600, 0, 100, 0, 1'b1, '{0, 0, 100, 0, 100, 0, 100}},
            // exactly on the near limit, then one past it with an energy equal to the peak
            '{FUNC_HIT, 600, 600, 1600, 50, 5, 1'b1, '{1600, 3, 100, 0, 150, 0, 50}},
            '{FUNC_HIT, 600, 600, 1601, 100, 0, 1'b1,
              '{1601, 3, 100, 0, 150, 100, 150}},
            // first overflow distance with zero energy
            '{FUNC_HIT, 600, 600, -29248, 0, 0, 1'b1,
              '{29248, 64, 100, 0, 150, 100, 0}},
            // position extremes, full-scale energy and a tie on it
            '{FUNC_HIT, -32768, -32768, -32768, 65535, 127, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
            '{FUNC_HIT, 32767, 32767, 32767, 65535, 0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
            '{FUNC_HIT, 32767, -32768, 0, 1, 64, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
            '{FUNC_HIT, 600, 600, 1599, 65534, 0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
            '{FUNC_READ, 0, 0, 0, 0, 3, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
            '{FUNC_READ, 0, 0, 0, 0, 64, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
            '{FUNC_READ, 0, 0, 0, 0, 63, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
            '{FUNC_READ, 0, 0, 0, 0, 65, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
            '{FUNC_HIT, 601, 601, 1, 65535, 0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
            // either side of the first bin boundary
            '{FUNC_HIT, 1057, 600, 0, 7, 0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
            '{FUNC_HIT, 1056, 600, 0, 9, 0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
            '{FUNC_READ, 0, 0, 0, 0, 1, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
            '{FUNC_READ, 0, 0, 0, 0, 0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}}
        };

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            send_word(dir_rows[i].f, dir_rows[i].x[POS_W-1:0], dir_rows[i].y[POS_W-1:0],
                      dir_rows[i].z[POS_W-1:0], dir_rows[i].e[EN_W-1:0],
                      dir_rows[i].rb[READ_BIN_W-1:0], pause_len(), predicted);
            pending_results.push_back(dir_rows[i].typed ? dir_rows[i].want : predicted);
        end
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            vx  = CFG_DATA_W'($urandom);
            vy  = CFG_DATA_W'($urandom);
            vz  = CFG_DATA_W'($urandom);
            thr = CFG_DATA_W'($urandom_range(0, 20000));
            bw  = CFG_DATA_W'($urandom_range(1, 2000));
            case (ph)
                1:
                begin
                    // most negative vertex, zero threshold, zero width as width one
                    vx  = {1'b1, 16'h8000};
                    vy  = {1'b0, 16'h8000};
                    vz  = {1'b1, 16'h8000};
                    thr = '0;
                    bw  = '0;
                end
                2:
                begin
                    vx  = {1'b0, 16'h7FFF};
                    vy  = {1'b1, 16'h7FFF};
                    vz  = {1'b0, 16'h7FFF};
                    thr = '1;
                    bw  = {1'b1, 16'hFFFF};
                end
                3:
                begin
                    vx = '0;
                    vy = '0;
                    vz = '0;
                    bw = CFG_DATA_W'(1);
                end
                default: ;
            endcase
            program_regs(vx, vy, vz, thr, bw, ph % 2 == 0);
            steady = (ph % 3 == 2);
            spread = ((bin_span == 0) ? 1 : longint'(bin_span)) * 40;
            if (spread > 40000)
                spread = 40000;

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(0, 49) == 0)
                    drain();
                f  = FUNC_HIT;
                hx = POS_W'($urandom);
                hy = POS_W'($urandom);
                hz = POS_W'($urandom);
                rb = READ_BIN_W'($urandom);
                en = pick_energy();
                roll = $urandom_range(0, 99);
                if (roll < 15)
                begin
                    f  = FUNC_READ;
                    rb = ($urandom_range(0, 9) < 7) ? READ_BIN_W'($urandom_range(0, BINS))
                                                    : READ_BIN_W'($urandom_range(0, 127));
                end
                else if (roll < 20)
                begin
                    hx = around(org_x, 0);
                    hy = around(org_y, 0);
                    hz = around(org_z, 0);
                end
                else if (roll < 27)
                begin
                    // on the near limit along one axis, give or take one
                    hx = around(org_x + longint'(near_lim) + $urandom_range(0, 2) - 1, 0);
                    hy = around(org_y, 0);
                    hz = around(org_z, 0);
                end
                else if (roll < 80)
                begin
                    hx = around(org_x, spread);
                    hy = around(org_y, spread);
                    hz = around(org_z, spread);
                end
                send_word(f, hx, hy, hz, en, rb, steady ? 0 : pause_len(), predicted);
                pending_results.push_back(predicted);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
